// ===== rtl/wcbs_pkg.sv =====
// Shared types and constants for the weighted class budget split block.
`default_nettype none

package wcbs_pkg;

   // Fixed field widths of the request, response and register channels
   localparam int unsigned FIELD_W     = 16;
   localparam int unsigned MASK_W      = 4;
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RUN_BUDGET_DEPTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LATENCY_MODE = 8'd1;

   // Register reset values
   localparam logic [FIELD_W-1:0] DEPTH_RESET = 16'd200;

   // Class weights and rounding constants
   localparam int unsigned W_URGENT          = 64;
   localparam int unsigned W_NORMAL          = 48;
   localparam int unsigned W_BULK            = 16;
   localparam int unsigned W_HEAVY_FIRST     = 1;
   localparam int unsigned NICE_ROUND        = 3;
   localparam int unsigned HEAVY_MIXED_SHIFT = 10;  // divide by 1024
   localparam int unsigned HEAVY_ONLY_SHIFT  = 7;   // divide by 128

   // Class slots, also the order in which shares are computed
   localparam logic [1:0] CLASS_URGENT = 2'd0;
   localparam logic [1:0] CLASS_NORMAL = 2'd1;
   localparam logic [1:0] CLASS_BULK   = 2'd2;
   localparam logic [1:0] CLASS_HEAVY  = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_LOAD,
      ST_WAIT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/wcbs_if.sv =====
// Request, response and register write channel interfaces of the budget split block.
`default_nettype none

interface wcbs_req_if;
   import wcbs_pkg::*;

   logic               valid;
   logic               ready;
   logic               new_round;
   logic [MASK_W-1:0]  class_mask;
   logic               remote_pending;
   logic               tasks_waiting;
   logic               niced_present;
   logic [FIELD_W-1:0] queued_total;
   logic [FIELD_W-1:0] listed_tasks;
   logic [FIELD_W-1:0] ran_last_pass;
   logic [FIELD_W-1:0] heavy_left;

   modport source (
      output valid, new_round, class_mask, remote_pending, tasks_waiting,
             niced_present, queued_total, listed_tasks, ran_last_pass, heavy_left,
      input  ready
   );
   modport sink (
      input  valid, new_round, class_mask, remote_pending, tasks_waiting,
             niced_present, queued_total, listed_tasks, ran_last_pass, heavy_left,
      output ready
   );
endinterface

interface wcbs_rsp_if;
   import wcbs_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] urgent_budget;
   logic [FIELD_W-1:0] normal_budget;
   logic [FIELD_W-1:0] bulk_budget;
   logic [FIELD_W-1:0] heavy_budget;
   logic [FIELD_W-1:0] pick_budget;
   logic               round_over;

   modport source (
      output valid, urgent_budget, normal_budget, bulk_budget, heavy_budget,
             pick_budget, round_over,
      input  ready
   );
   modport sink (
      input  valid, urgent_budget, normal_budget, bulk_budget, heavy_budget,
             pick_budget, round_over,
      output ready
   );
endinterface

interface wcbs_csr_if;
   import wcbs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/wcbs_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, shared by all class shares.
`default_nettype none

module wcbs_div #(
   parameter int unsigned CW = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [2*CW+1:0]   num,
   input  wire logic [CW:0]       den,
   output logic                   busy,
   output logic                   done,
   output logic [CW-1:0]          quot
);
   import wcbs_pkg::*;

   localparam int unsigned TW    = CW + 1;
   localparam int unsigned CNT_W = $clog2(CW);

   logic [TW-1:0]    rem_ff, rem_in;
   logic [CW-1:0]    sh_ff, sh_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [TW:0]      trial;
   logic             ge;

   // Trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      trial = {rem_ff, sh_ff[CW-1]};
      ge    = (trial >= {1'b0, den});
   end

   // Load on start, then shift one quotient bit in per cycle
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // Quotient fits in CW bits, so the upper numerator part is below den
         rem_in  = num[CW+TW-1:CW];
         sh_in   = num[CW-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? TW'(trial - {1'b0, den}) : TW'(trial);
         sh_in  = {sh_ff[CW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(CW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = sh_ff;

endmodule

`default_nettype wire

// ===== rtl/weighted_class_budget_split.sv =====
// Top level of the weighted class budget split: sequencer, datapath and registers.
// CW is COUNT_BITS capped at 16; the shares are computed one after another on the shared
// divider. A new request is taken only in idle, once the previous result has been loaded;
// a response waiting in the output register does not block the next request, but the next
// result holds until it drains.
// Reset: synchronous, active high; carried budget clears, depth returns to 200.
`default_nettype none

module weighted_class_budget_split #(
   parameter int unsigned COUNT_BITS = 16
) (
   input wire logic      clock,
   input wire logic      reset,
   wcbs_req_if.sink      req_chan,
   wcbs_rsp_if.source    rsp_chan,
   wcbs_csr_if.sink      csr_chan
);
   import wcbs_pkg::*;

   localparam int unsigned CW = (COUNT_BITS < FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam int unsigned TW = CW + 1;
   localparam int unsigned PW = CW + TW;
   localparam int unsigned NW = PW + 1;

   // Configuration registers
   logic [FIELD_W-1:0] depth_ff;
   logic               llm_ff;

   // Sequencer
   state_type state_ff, state_in;
   logic [1:0] idx_ff;

   // Captured request
   logic              first_ff;
   logic [MASK_W-1:0] mask_ff;
   logic              remote_ff, waiting_ff, niced_ff;
   logic [CW-1:0]     queued_ff, listed_ff, ran_ff, hleft_ff;

   // Pass state and working registers
   logic [CW-1:0] carried_ff;
   logic [CW-1:0] budget_ff;
   logic [TW-1:0] w_ff [4];
   logic [TW-1:0] total_ff;
   logic          over_ff;
   logic [PW-1:0] prod_ff;
   logic [CW-1:0] share_ff [4];

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_urgent_ff, rsp_normal_ff, rsp_bulk_ff;
   logic [FIELD_W-1:0] rsp_heavy_ff, rsp_pick_ff;
   logic               rsp_over_ff;

   // Sequencer outputs
   logic req_ready;
   logic req_take;
   logic div_start;
   logic rsp_load;

   // Divider connection
   logic [NW-1:0] div_num;
   logic          div_busy, div_done;
   logic [CW-1:0] div_quot;

   // Budget and weight logic
   logic [CW-1:0] depth_c, nice_c, b1_c, first_budget_c, cont_budget_c, budget_c;
   logic [CW:0]   nice_sum_c, dbl_c;
   logic          halve_c;
   logic [TW-1:0] wu_c, wn_c, wb_c, wh_c, total_c;
   logic          over_c;

   // Heavy cap and pick logic
   logic [CW-1:0] q_shift_c, cap_c, heavy_c, pick_c;

   //------------------------------------------------------------------
   // Accept register writes at any time
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
         llm_ff   <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_RUN_BUDGET_DEPTH: depth_ff <= csr_chan.wdata;
            CSR_LOW_LATENCY_MODE: llm_ff   <= csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_PREP;
         ST_PREP:   state_in = over_c ? ST_FINISH : ST_MUL;
         ST_MUL:    state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) state_in = (idx_ff == CLASS_HEAVY) ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD:   div_start = 1'b1;
         ST_FINISH: rsp_load  = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign req_chan.ready = req_ready;
   assign req_take       = req_chan.valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   //------------------------------------------------------------------
   // Capture the request
   always_ff @(posedge clock) begin
      if (req_take) begin
         first_ff   <= req_chan.new_round;
         mask_ff    <= req_chan.class_mask;
         remote_ff  <= req_chan.remote_pending;
         waiting_ff <= req_chan.tasks_waiting;
         niced_ff   <= req_chan.niced_present;
         queued_ff  <= CW'(req_chan.queued_total);
         listed_ff  <= CW'(req_chan.listed_tasks);
         ran_ff     <= CW'(req_chan.ran_last_pass);
         hleft_ff   <= CW'(req_chan.heavy_left);
      end
   end

   //------------------------------------------------------------------
   // Pass budget: adjusted depth on a first pass, carried minus ran otherwise
   always_comb begin
      depth_c        = CW'(depth_ff);
      nice_sum_c     = (CW+1)'(depth_c) + (CW+1)'(NICE_ROUND);
      nice_c         = CW'(nice_sum_c >> 2);
      b1_c           = niced_ff ? nice_c : depth_c;
      dbl_c          = {b1_c, 1'b0};
      halve_c        = (queued_ff > b1_c) && ((CW+1)'(queued_ff) <= dbl_c);
      first_budget_c = halve_c ? (queued_ff >> 1) : b1_c;
      cont_budget_c  = (carried_ff > ran_ff) ? (carried_ff - ran_ff) : '0;
      budget_c       = first_ff ? first_budget_c : cont_budget_c;
   end

   // Class weights and their total
   always_comb begin
      wu_c = (mask_ff[0] || remote_ff)  ? TW'(W_URGENT) : '0;
      wn_c = (mask_ff[1] || waiting_ff) ? TW'(W_NORMAL) : '0;
      wb_c = mask_ff[2] ? TW'(W_BULK) : '0;
      if (first_ff) wh_c = mask_ff[3] ? TW'(W_HEAVY_FIRST) : '0;
      else          wh_c = TW'(hleft_ff);
      total_c = wu_c + wn_c + wb_c + wh_c;
      over_c  = (total_c == '0) || (budget_c == '0);
   end

   // Numerator of the ceiling division: budget*weight + total - 1
   assign div_num = NW'(prod_ff) + NW'(total_ff) - NW'(1);

   wcbs_div #(
      .CW (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (total_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Working registers: set up the pass, multiply, collect shares
   always_ff @(posedge clock) begin
      if (reset) begin
         carried_ff <= '0;
         idx_ff     <= CLASS_URGENT;
      end else begin
         case (state_ff)
            ST_PREP: begin
               carried_ff <= budget_c;
               idx_ff     <= CLASS_URGENT;
            end
            ST_WAIT: if (div_done) idx_ff <= idx_ff + 2'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PREP: begin
            budget_ff           <= budget_c;
            w_ff[CLASS_URGENT]  <= wu_c;
            w_ff[CLASS_NORMAL]  <= wn_c;
            w_ff[CLASS_BULK]    <= wb_c;
            w_ff[CLASS_HEAVY]   <= wh_c;
            total_ff            <= total_c;
            over_ff             <= over_c;
            // Shares stay zero when the round is over
            for (int i = 0; i < 4; i++) share_ff[i] <= '0;
         end
         ST_MUL:  prod_ff <= PW'(budget_ff * w_ff[idx_ff]);
         ST_WAIT: if (div_done) share_ff[idx_ff] <= div_quot;
         default: ;
      endcase
   end

   //------------------------------------------------------------------
   // Cap the heavy share and derive the pick budget
   always_comb begin
      q_shift_c = (mask_ff[2:0] != '0) ? (queued_ff >> HEAVY_MIXED_SHIFT)
                                       : (queued_ff >> HEAVY_ONLY_SHIFT);
      cap_c     = llm_ff ? CW'(1) : (q_shift_c + CW'(1));
      heavy_c   = share_ff[CLASS_HEAVY];
      if ((heavy_c > CW'(1)) && (heavy_c > cap_c)) heavy_c = cap_c;
      pick_c    = (share_ff[CLASS_NORMAL] > listed_ff) ?
                  (share_ff[CLASS_NORMAL] - listed_ff) : '0;
   end

   // Output register: load when free or being drained, drop on take
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)            rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_urgent_ff <= FIELD_W'(share_ff[CLASS_URGENT]);
         rsp_normal_ff <= FIELD_W'(share_ff[CLASS_NORMAL]);
         rsp_bulk_ff   <= FIELD_W'(share_ff[CLASS_BULK]);
         rsp_heavy_ff  <= FIELD_W'(heavy_c);
         rsp_pick_ff   <= FIELD_W'(pick_c);
         rsp_over_ff   <= over_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.urgent_budget = rsp_urgent_ff;
   assign rsp_chan.normal_budget = rsp_normal_ff;
   assign rsp_chan.bulk_budget   = rsp_bulk_ff;
   assign rsp_chan.heavy_budget  = rsp_heavy_ff;
   assign rsp_chan.pick_budget   = rsp_pick_ff;
   assign rsp_chan.round_over    = rsp_over_ff;

   //------------------------------------------------------------------
   // Assertions

   // The divider is never restarted while it is still iterating
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider started while busy");

   // An accepted request always moves the sequencer into setup
   assert property (@(posedge clock) disable iff (reset)
                    req_take |=> (state_ff == ST_PREP))
      else $error("request accepted without entering setup");

   // A finished round reports no budget for any class
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_over_ff) |->
                    (rsp_urgent_ff == '0 && rsp_normal_ff == '0 && rsp_bulk_ff == '0 &&
                     rsp_heavy_ff == '0 && rsp_pick_ff == '0))
      else $error("round over with nonzero budget");

   // The pick budget never exceeds the normal budget
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff |-> (rsp_pick_ff <= rsp_normal_ff))
      else $error("pick budget above normal budget");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for the weighted class budget split block: directed and random passes.

module tb_top;
   import wcbs_pkg::*;

   // Request accept to response valid at the default count width
   localparam int unsigned PASS_LATENCY    = 4 * (FIELD_W + 3) + 2;
   // Longest stretch without any handshake before the run is declared hung
   localparam int unsigned IDLE_LIMIT      = 4000;
   localparam int unsigned RSP_HOLD_CYCLES = 600;
   localparam int unsigned PHASE_REQUESTS  = 140;
   localparam int unsigned RANDOM_PHASES   = 7;
   localparam int unsigned MAX_REPORTS     = 20;

   typedef struct packed {
      logic               new_round;
      logic [MASK_W-1:0]  class_mask;
      logic               remote_pending;
      logic               tasks_waiting;
      logic               niced_present;
      logic [FIELD_W-1:0] queued_total;
      logic [FIELD_W-1:0] listed_tasks;
      logic [FIELD_W-1:0] ran_last_pass;
      logic [FIELD_W-1:0] heavy_left;
   } pass_request_type;

   typedef struct packed {
      logic [FIELD_W-1:0] urgent_budget;
      logic [FIELD_W-1:0] normal_budget;
      logic [FIELD_W-1:0] bulk_budget;
      logic [FIELD_W-1:0] heavy_budget;
      logic [FIELD_W-1:0] pick_budget;
      logic               round_over;
   } pass_budget_type;

   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PATTERN
   } rsp_style_type;

   logic clock;
   logic reset;

   wcbs_req_if req_chan ();
   wcbs_rsp_if rsp_chan ();
   wcbs_csr_if csr_chan ();

   weighted_class_budget_split u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor copy of the registers and the carried pass budget
   logic [FIELD_W-1:0] model_depth;
   logic               model_low_latency;
   logic [FIELD_W-1:0] model_carried;
   pass_budget_type    expected_budgets [$];

   int unsigned error_count       = 0;
   int unsigned requests_sent     = 0;
   int unsigned responses_seen    = 0;
   int unsigned over_count        = 0;
   int unsigned capped_count      = 0;
   int unsigned setting_count     = 0;

   // Sender burst shaping and receiver stall shaping
   int unsigned   burst_left  = 0;
   int unsigned   gap_max     = 6;
   rsp_style_type rsp_style   = RSP_RANDOM;
   logic [7:0]    rsp_pattern = 8'b1011_0110;
   logic          rsp_hold;
   event          rsp_hold_go;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned ceil_share(longint unsigned budget,
                                                  longint unsigned weight,
                                                  longint unsigned total);
      return (budget * weight + total - 64'd1) / total;
   endfunction

   // Split one pass budget across the classes and advance the carried budget
   function automatic pass_budget_type split_budget(pass_request_type r);
      longint unsigned budget;
      longint unsigned total;
      longint unsigned cap;
      longint unsigned w_urgent = 64'd0;
      longint unsigned w_normal = 64'd0;
      longint unsigned w_bulk   = 64'd0;
      longint unsigned w_heavy;
      longint unsigned s_heavy;
      longint unsigned queued;
      pass_budget_type b;
      b = '0;
      queued = 64'(r.queued_total);
      if (r.new_round) begin
         budget = 64'(model_depth);
         if (r.niced_present) budget = (budget + 64'(NICE_ROUND)) / 64'd4;
         if (budget < queued && queued <= 64'd2 * budget)
            budget = queued / 64'd2;
         w_heavy = r.class_mask[3] ? 64'(W_HEAVY_FIRST) : 64'd0;
      end else begin
         budget  = (model_carried > r.ran_last_pass) ?
                   64'(model_carried - r.ran_last_pass) : 64'd0;
         w_heavy = 64'(r.heavy_left);
      end
      model_carried = FIELD_W'(budget);

      if (r.class_mask[0] || r.remote_pending) w_urgent = 64'(W_URGENT);
      if (r.class_mask[1] || r.tasks_waiting) w_normal = 64'(W_NORMAL);
      if (r.class_mask[2]) w_bulk = 64'(W_BULK);
      total = w_urgent + w_normal + w_bulk + w_heavy;

      if (total == 64'd0 || budget == 64'd0) begin
         b.round_over = 1'b1;
      end else begin
         b.urgent_budget = FIELD_W'(ceil_share(budget, w_urgent, total));
         b.normal_budget = FIELD_W'(ceil_share(budget, w_normal, total));
         b.bulk_budget   = FIELD_W'(ceil_share(budget, w_bulk, total));
         s_heavy         = ceil_share(budget, w_heavy, total);
         // Cap the heavy share only once it exceeds a single entry
         if (s_heavy > 64'd1) begin
            if (model_low_latency) cap = 64'd1;
            else if (r.class_mask[2:0] != '0) cap = 64'd1 + (queued >> HEAVY_MIXED_SHIFT);
            else cap = 64'd1 + (queued >> HEAVY_ONLY_SHIFT);
            if (s_heavy > cap) begin
               s_heavy = cap;
               capped_count++;
            end
         end
         b.heavy_budget = FIELD_W'(s_heavy);
         b.pick_budget  = (b.normal_budget > r.listed_tasks) ?
                          b.normal_budget - r.listed_tasks : '0;
      end
      return b;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_budget(pass_budget_type got, pass_budget_type want);
      if (got.urgent_budget !== want.urgent_budget)
         report_mismatch($sformatf("urgent_budget got %0d expected %0d",
                                   got.urgent_budget, want.urgent_budget));
      if (got.normal_budget !== want.normal_budget)
         report_mismatch($sformatf("normal_budget got %0d expected %0d",
                                   got.normal_budget, want.normal_budget));
      if (got.bulk_budget !== want.bulk_budget)
         report_mismatch($sformatf("bulk_budget got %0d expected %0d",
                                   got.bulk_budget, want.bulk_budget));
      if (got.heavy_budget !== want.heavy_budget)
         report_mismatch($sformatf("heavy_budget got %0d expected %0d",
                                   got.heavy_budget, want.heavy_budget));
      if (got.pick_budget !== want.pick_budget)
         report_mismatch($sformatf("pick_budget got %0d expected %0d",
                                   got.pick_budget, want.pick_budget));
      if (got.round_over !== want.round_over)
         report_mismatch($sformatf("round_over got %0b expected %0b",
                                   got.round_over, want.round_over));
   endtask

   // Track register writes, predict each accepted request, check each response
   always @(posedge clock) begin : monitor
      pass_request_type seen_req;
      pass_budget_type  seen_rsp;
      pass_budget_type  want;
      if (reset) begin
         model_depth       = DEPTH_RESET;
         model_low_latency = 1'b0;
         model_carried     = '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == CSR_RUN_BUDGET_DEPTH) model_depth = csr_chan.wdata;
            else if (csr_chan.index == CSR_LOW_LATENCY_MODE)
               model_low_latency = csr_chan.wdata[0];
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            responses_seen++;
            seen_rsp = {rsp_chan.urgent_budget, rsp_chan.normal_budget, rsp_chan.bulk_budget,
                        rsp_chan.heavy_budget, rsp_chan.pick_budget, rsp_chan.round_over};
            if (expected_budgets.size() == 0)
               report_mismatch("response arrived with no request pending");
            else
               compare_budget(seen_rsp, expected_budgets.pop_front());
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_req = {req_chan.new_round, req_chan.class_mask, req_chan.remote_pending,
                        req_chan.tasks_waiting, req_chan.niced_present, req_chan.queued_total,
                        req_chan.listed_tasks, req_chan.ran_last_pass, req_chan.heavy_left};
            want = split_budget(seen_req);
            if (want.round_over) over_count++;
            expected_budgets.push_back(want);
         end
      end
   end

   // Response stall hold-off, counted here once triggered
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(rsp_hold_go);
         rsp_hold = 1'b1;
         repeat (RSP_HOLD_CYCLES) @(posedge clock);
         rsp_hold = 1'b0;
      end
   end

   // Drive response ready on the current stall style
   initial begin
      logic [2:0] rsp_phase;
      rsp_phase = '0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            case (rsp_style)
               RSP_ALWAYS: rsp_chan.ready <= 1'b1;
               RSP_RANDOM: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: begin
                  rsp_chan.ready <= rsp_pattern[rsp_phase];
                  rsp_phase = rsp_phase + 1'b1;
               end
            endcase
         end
      end
   end

   // End the run when no handshake of any kind happens for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready) || (csr_chan.valid && csr_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no handshake for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, expected_budgets.size());
      $display("tb_top failed");
      $finish;
   end

   // Offer one request, hold it until accepted, then maybe open a gap
   task automatic send_request(pass_request_type r);
      req_chan.valid          <= 1'b1;
      req_chan.new_round      <= r.new_round;
      req_chan.class_mask     <= r.class_mask;
      req_chan.remote_pending <= r.remote_pending;
      req_chan.tasks_waiting  <= r.tasks_waiting;
      req_chan.niced_present  <= r.niced_present;
      req_chan.queued_total   <= r.queued_total;
      req_chan.listed_tasks   <= r.listed_tasks;
      req_chan.ran_last_pass  <= r.ran_last_pass;
      req_chan.heavy_left     <= r.heavy_left;
      do @(posedge clock); while (!req_chan.ready);
      requests_sent++;
      if (gap_max != 0) begin
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
            burst_left = $urandom_range(0, 7);
         end
      end
   endtask

   // Drop valid and hold until every pending response has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (responses_seen < requests_sent) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.wdata <= data;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [CSR_DATA_W-1:0] depth, logic [CSR_DATA_W-1:0] mode);
      write_register(CSR_RUN_BUDGET_DEPTH, depth);
      write_register(CSR_LOW_LATENCY_MODE, mode);
      setting_count++;
   endtask

   function automatic pass_request_type make_request(logic first, logic [MASK_W-1:0] mask,
                                                     logic remote, logic waiting, logic niced,
                                                     logic [FIELD_W-1:0] queued,
                                                     logic [FIELD_W-1:0] listed,
                                                     logic [FIELD_W-1:0] ran,
                                                     logic [FIELD_W-1:0] hleft);
      return {first, mask, remote, waiting, niced, queued, listed, ran, hleft};
   endfunction

   // Random pass content biased toward halving, capping and exhaustion
   function automatic pass_request_type random_request(int unsigned depth_hint);
      pass_request_type r;
      int unsigned      eff;
      int unsigned      hi;
      r.new_round      = 1'($urandom);
      r.class_mask     = ($urandom_range(0, 3) == 0) ? 4'h8 : MASK_W'($urandom);
      r.remote_pending = 1'($urandom);
      r.tasks_waiting  = 1'($urandom);
      r.niced_present  = ($urandom_range(0, 3) == 0);
      eff = r.niced_present ? (depth_hint + NICE_ROUND) / 4 : depth_hint;
      hi  = (2 * eff + 1 > 16'hFFFF) ? 16'hFFFF : 2 * eff + 1;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.queued_total = FIELD_W'($urandom_range(0, 300));
         4, 5:       r.queued_total = FIELD_W'($urandom_range(eff, hi));
         6:          r.queued_total = FIELD_W'($urandom_range(1024, 20000));
         7:          r.queued_total = 16'hFFFF;
         default:    r.queued_total = FIELD_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       r.listed_tasks = '0;
         1:       r.listed_tasks = FIELD_W'($urandom);
         default: r.listed_tasks = FIELD_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 9))
         0, 1:    r.ran_last_pass = FIELD_W'($urandom_range(0, 3));
         2:       r.ran_last_pass = FIELD_W'($urandom);
         3:       r.ran_last_pass = FIELD_W'($urandom_range(depth_hint / 2,
                                       (depth_hint < 16'hFFFF) ? depth_hint + 1 : depth_hint));
         default: r.ran_last_pass = FIELD_W'($urandom_range(0, depth_hint / 3 + 1));
      endcase
      case ($urandom_range(0, 4))
         0, 1:    r.heavy_left = FIELD_W'($urandom_range(0, 3));
         2, 3:    r.heavy_left = FIELD_W'($urandom_range(0, 300));
         default: r.heavy_left = FIELD_W'($urandom);
      endcase
      return r;
   endfunction

   // One round: a first pass followed by up to five continuation passes
   task automatic send_random_round(int unsigned depth_hint);
      pass_request_type r;
      int unsigned      passes;
      r = random_request(depth_hint);
      r.new_round = 1'b1;
      send_request(r);
      passes = $urandom_range(0, 5);
      repeat (passes) begin
         r = random_request(depth_hint);
         r.new_round = 1'b0;
         send_request(r);
      end
   endtask

   // Reset register values: empty classes, halving, heavy caps, exhaustion
   task automatic check_default_passes();
      send_request(make_request(1'b0, 4'hF, 1'b1, 1'b1, 1'b0,
                                16'd10, 16'd0, 16'd0, 16'd5));
      send_request(make_request(1'b1, 4'h0, 1'b0, 1'b0, 1'b1,
                                16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
      send_request(make_request(1'b0, 4'h0, 1'b0, 1'b0, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'hF, 1'b1, 1'b1, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'h1, 1'b0, 1'b0, 1'b0,
                                16'd300, 16'hFFFF, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'h2, 1'b0, 1'b0, 1'b1,
                                16'd80, 16'd3, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'h8, 1'b0, 1'b0, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'h8, 1'b0, 1'b0, 1'b0,
                                16'd1000, 16'd0, 16'd10, 16'hFFFF));
      send_request(make_request(1'b0, 4'h9, 1'b0, 1'b0, 1'b0,
                                16'd5000, 16'd0, 16'd0, 16'd100));
      send_request(make_request(1'b0, 4'hF, 1'b1, 1'b1, 1'b1,
                                16'd0, 16'd0, 16'hFFFF, 16'd0));
      send_request(make_request(1'b1, 4'h0, 1'b1, 1'b0, 1'b0,
                                16'd400, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'h0, 1'b0, 1'b1, 1'b0,
                                16'd401, 16'd10, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'h6, 1'b0, 1'b1, 1'b0,
                                16'd0, 16'd0, 16'd200, 16'd7));
   endtask

   // Zero, one and full-scale depth, with and without low latency mode
   task automatic check_depth_extremes();
      wait_for_results();
      apply_setting(16'd0, 16'd0);
      send_request(make_request(1'b1, 4'hF, 1'b1, 1'b1, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'hF, 1'b1, 1'b1, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd9));
      wait_for_results();
      apply_setting(16'd1, 16'd0);
      send_request(make_request(1'b1, 4'hF, 1'b0, 1'b0, 1'b0,
                                16'd2, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'hF, 1'b0, 1'b0, 1'b1,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'hF, 1'b0, 1'b0, 1'b0,
                                16'd0, 16'd0, 16'd1, 16'd1));
      wait_for_results();
      apply_setting(16'hFFFF, 16'd1);
      send_request(make_request(1'b1, 4'hF, 1'b1, 1'b1, 1'b0,
                                16'd0, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b1, 4'hF, 1'b0, 1'b0, 1'b1,
                                16'd20000, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'h8, 1'b0, 1'b0, 1'b0,
                                16'd0, 16'd0, 16'd1, 16'hFFFF));
      wait_for_results();
      apply_setting(16'hFFFF, 16'hFFFE);
      send_request(make_request(1'b1, 4'h8, 1'b0, 1'b0, 1'b0,
                                16'hFFFF, 16'd0, 16'd0, 16'd0));
      send_request(make_request(1'b0, 4'h8, 1'b0, 1'b0, 1'b0,
                                16'h8000, 16'd0, 16'd0, 16'hFFFF));
   endtask

   // Hold off responses so the block fills and stalls requests, then pause
   task automatic check_response_backpressure();
      pass_request_type r;
      wait_for_results();
      apply_setting(16'd300, 16'd0);
      rsp_style  = RSP_ALWAYS;
      gap_max    = 0;
      -> rsp_hold_go;
      for (int i = 0; i < 8; i++) begin
         r = random_request(300);
         r.new_round = (i % 3 == 0);
         send_request(r);
      end
      wait_for_results();
      send_random_round(300);
   endtask

   // Random rounds under several register settings and idling styles
   task automatic check_random_rounds();
      logic [CSR_DATA_W-1:0] depth;
      logic                  mode;
      int unsigned           phase_start;
      logic [95:0]           noise;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         mode = 1'($urandom);
         case (p)
            0:       begin depth = 16'd1;     mode = 1'b0; end
            1:       begin depth = 16'hFFFF;  mode = 1'b0; end
            2:       begin depth = 16'hFFFF;  mode = 1'b1; end
            3:       begin depth = 16'd4;     mode = 1'b1; end
            4:       depth = 16'd200;
            5:       depth = CSR_DATA_W'($urandom_range(1, 2000));
            default: depth = CSR_DATA_W'($urandom_range(1, 16'hFFFF));
         endcase
         wait_for_results();
         apply_setting(depth, {(CSR_DATA_W-1)'($urandom), mode});
         rsp_style   = rsp_style_type'($urandom_range(0, 2));
         rsp_pattern = 8'($urandom) | 8'h01;
         gap_max     = (p % 3 == 0) ? 0 : $urandom_range(2, 24);
         burst_left  = 0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(0, 9) == 0) begin
               noise = {$urandom, $urandom, $urandom};
               send_request(noise[$bits(pass_request_type)-1:0]);
            end else begin
               send_random_round(32'(depth));
            end
         end
      end
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.new_round      <= 1'b0;
      req_chan.class_mask     <= '0;
      req_chan.remote_pending <= 1'b0;
      req_chan.tasks_waiting  <= 1'b0;
      req_chan.niced_present  <= 1'b0;
      req_chan.queued_total   <= '0;
      req_chan.listed_tasks   <= '0;
      req_chan.ran_last_pass  <= '0;
      req_chan.heavy_left     <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.wdata          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_default_passes();
      check_depth_extremes();
      check_response_backpressure();
      check_random_rounds();

      // Drain, then allow one more pass time for any stray response
      wait_for_results();
      repeat (PASS_LATENCY + 8) @(posedge clock);
      $display("covered %0d requests under %0d register settings plus reset values",
               requests_sent, setting_count);
      $display("%0d passes closed the round, %0d heavy shares were capped",
               over_count, capped_count);
      if (error_count == 0 && expected_budgets.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
